### design/hrc_pkg.sv
// hrc_pkg: shared types, constants and divider step functions for the
// HSV/RGB converter. No dependencies.
package hrc_pkg;

  localparam int CHAN_BITS = 8;
  localparam int HUE_BITS = 11;
  localparam int HUE_CALC_BITS = HUE_BITS + 1;
  localparam int PROD_BITS = 2 * CHAN_BITS;

  localparam logic [CHAN_BITS-1:0] CHAN_MAX = '1;
  localparam logic [HUE_BITS-1:0] HUE_FULL = 11'd1536;

  // hue offsets for the max-channel cases, in 1/256 sector units
  localparam logic [HUE_CALC_BITS-1:0] HUE_OFS_RED = 12'd1536;
  localparam logic [HUE_CALC_BITS-1:0] HUE_OFS_GREEN = 12'd512;
  localparam logic [HUE_CALC_BITS-1:0] HUE_OFS_BLUE = 12'd1024;

  // quotients here never exceed 256, so 9 quotient bits suffice
  localparam int QUO_BITS = 9;
  localparam int DIV_STEPS = 3;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEPS;

  typedef struct packed {
    logic                 action;
    logic [HUE_BITS-1:0]  first_chan;
    logic [CHAN_BITS-1:0] second_chan;
    logic [CHAN_BITS-1:0] third_chan;
  } in_item_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]  first_out;
    logic [CHAN_BITS-1:0] second_out;
    logic [CHAN_BITS-1:0] third_out;
  } out_item_t;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef enum logic [1:0] {
    HC_RED   = 2'd0,
    HC_GREEN = 2'd1,
    HC_BLUE  = 2'd2
  } hue_case_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] rem;
    logic [QUO_BITS-1:0]  num;
    logic [QUO_BITS-1:0]  quo;
    logic [CHAN_BITS-1:0] den;
  } div_t;

  typedef struct packed {
    hue_case_t            hcase;
    logic                 neg;
    logic                 gray;
    logic                 black;
    logic [CHAN_BITS-1:0] vmax;
  } side_t;

  // partial remainder starts with the top dividend bits; valid when
  // dividend < den * 2**QUO_BITS, which holds for both divisions here
  function automatic div_t div_init(input logic [PROD_BITS-1:0] dividend,
                                    input logic [CHAN_BITS-1:0] den);
    div_t d;
    d.rem = CHAN_BITS'(dividend[PROD_BITS-1:QUO_BITS]);
    d.num = dividend[QUO_BITS-1:0];
    d.quo = '0;
    d.den = den;
    return d;
  endfunction

  // one restoring step: one quotient bit
  function automatic div_t div_step(input div_t d);
    logic [CHAN_BITS:0] t;
    div_t n;
    t = {d.rem, d.num[QUO_BITS-1]};
    n = d;
    n.num = {d.num[QUO_BITS-2:0], 1'b0};
    if (t >= {1'b0, d.den}) begin
      n.rem = CHAN_BITS'(t - {1'b0, d.den});
      n.quo = {d.quo[QUO_BITS-2:0], 1'b1};
    end else begin
      n.rem = t[CHAN_BITS-1:0];
      n.quo = {d.quo[QUO_BITS-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

### design/hrc_div_stage.sv
// hrc_div_stage: one registered slice of the pipelined restoring divider,
// DIV_STEPS quotient bits per slice. Depends on hrc_pkg.
module hrc_div_stage (
  input  logic          clk,
  input  hrc_pkg::div_t d_in,
  output hrc_pkg::div_t d_out
);

  hrc_pkg::div_t d_nxt;
  hrc_pkg::div_t d_r;

  always_comb begin
    d_nxt = d_in;
    for (int i = 0; i < hrc_pkg::DIV_STEPS; i++) begin
      d_nxt = hrc_pkg::div_step(d_nxt);
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

### design/hrc_hsv2rgb.sv
// hrc_hsv2rgb: four-stage HSV to RGB datapath (multiply, /255, multiply,
// select and offset). Depends on hrc_pkg.
module hrc_hsv2rgb (
  input  logic               clk,
  input  hrc_pkg::in_item_t  in_item,
  output hrc_pkg::out_item_t res
);

  localparam int CB = hrc_pkg::CHAN_BITS;
  localparam int PB = hrc_pkg::PROD_BITS;

  logic [hrc_pkg::HUE_BITS-1:0] hue_w;
  logic [PB:0] sum_w;
  logic [CB:0] k_w;
  logic [CB-1:0] m_w, x_w, r_w, g_w, b_w;

  hrc_pkg::sector_t sec1_r, sec1_nxt, sec2_r, sec3_r;
  logic [CB-1:0] f1_r, f1_nxt, f2_r;
  logic [CB-1:0] v1_r, v1_nxt, v2_r, v3_r;
  logic [PB-1:0] prod1_r, prod1_nxt;
  logic [CB-1:0] c2_r, c2_nxt, c3_r;
  logic [PB:0] xp3_r, xp3_nxt;
  hrc_pkg::out_item_t res4_r, res4_nxt;

  // stage 1: hue wrap, sector split, v*s
  always_comb begin
    if (in_item.first_chan >= hrc_pkg::HUE_FULL) begin
      hue_w = in_item.first_chan - hrc_pkg::HUE_FULL;
    end else begin
      hue_w = in_item.first_chan;
    end
    sec1_nxt = hrc_pkg::sector_t'(hue_w[hrc_pkg::HUE_BITS-1:CB]);
    f1_nxt = hue_w[CB-1:0];
    v1_nxt = in_item.third_chan;
    prod1_nxt = PB'(in_item.second_chan) * PB'(in_item.third_chan);
  end

  // stage 2: c = prod / 255, exact for 16-bit products
  always_comb begin
    sum_w = (PB+1)'(prod1_r) + (PB+1)'(prod1_r >> CB) + (PB+1)'(1);
    c2_nxt = sum_w[PB-1:CB];
  end

  // stage 3: c times the ramp within the sector
  always_comb begin
    if (sec2_r[0]) begin
      k_w = (CB+1)'(1 << CB) - (CB+1)'(f2_r);
    end else begin
      k_w = (CB+1)'(f2_r);
    end
    xp3_nxt = (PB+1)'(c2_r) * (PB+1)'(k_w);
  end

  // stage 4: place c and x by sector, add m
  always_comb begin
    x_w = xp3_r[PB-1:CB];
    m_w = v3_r - c3_r;
    r_w = '0;
    g_w = '0;
    b_w = '0;
    case (sec3_r)
      hrc_pkg::SEC_RY: begin r_w = c3_r; g_w = x_w; end
      hrc_pkg::SEC_YG: begin r_w = x_w;  g_w = c3_r; end
      hrc_pkg::SEC_GC: begin g_w = c3_r; b_w = x_w; end
      hrc_pkg::SEC_CB: begin g_w = x_w;  b_w = c3_r; end
      hrc_pkg::SEC_BM: begin r_w = x_w;  b_w = c3_r; end
      default:         begin r_w = c3_r; b_w = x_w; end
    endcase
    res4_nxt.first_out = hrc_pkg::HUE_BITS'(r_w + m_w);
    res4_nxt.second_out = g_w + m_w;
    res4_nxt.third_out = b_w + m_w;
  end

  always_ff @(posedge clk) begin
    sec1_r  <= sec1_nxt;
    f1_r    <= f1_nxt;
    v1_r    <= v1_nxt;
    prod1_r <= prod1_nxt;
    sec2_r  <= sec1_r;
    f2_r    <= f1_r;
    v2_r    <= v1_r;
    c2_r    <= c2_nxt;
    sec3_r  <= sec2_r;
    v3_r    <= v2_r;
    c3_r    <= c2_r;
    xp3_r   <= xp3_nxt;
    res4_r  <= res4_nxt;
  end

  assign res = res4_r;

endmodule

### design/hrc_rgb2hsv.sv
// hrc_rgb2hsv: RGB to HSV datapath: max/min front stage, then three
// divider slices for hue and saturation. Depends on hrc_pkg, hrc_div_stage.
module hrc_rgb2hsv (
  input  logic               clk,
  input  hrc_pkg::in_item_t  in_item,
  output hrc_pkg::out_item_t res
);

  localparam int CB = hrc_pkg::CHAN_BITS;
  localparam int PB = hrc_pkg::PROD_BITS;
  localparam int HC = hrc_pkg::HUE_CALC_BITS;
  localparam int NS = hrc_pkg::DIV_STAGES;

  logic [CB-1:0] r_w, g_w, b_w, mx_w, mn_w, delta_w, absd_w;
  logic [CB:0] diff_w;
  hrc_pkg::side_t side_nxt;
  hrc_pkg::div_t hue_d1_nxt, sat_d1_nxt;

  hrc_pkg::side_t side_r [0:NS];
  hrc_pkg::div_t hue_d [0:NS];
  hrc_pkg::div_t sat_d [0:NS];
  hrc_pkg::div_t hue_d0_r, sat_d0_r;

  logic [HC-1:0] ofs_w, h_w, hw_w;
  logic adj_w;

  always_comb begin
    if (in_item.first_chan > hrc_pkg::HUE_BITS'(hrc_pkg::CHAN_MAX)) begin
      r_w = hrc_pkg::CHAN_MAX;
    end else begin
      r_w = in_item.first_chan[CB-1:0];
    end
    g_w = in_item.second_chan;
    b_w = in_item.third_chan;
    mx_w = r_w;
    mn_w = r_w;
    if (g_w > mx_w) mx_w = g_w;
    if (b_w > mx_w) mx_w = b_w;
    if (g_w < mn_w) mn_w = g_w;
    if (b_w < mn_w) mn_w = b_w;
    delta_w = mx_w - mn_w;
    // ties go to red, then green
    if (r_w >= g_w && r_w >= b_w) begin
      side_nxt.hcase = hrc_pkg::HC_RED;
      diff_w = {1'b0, g_w} - {1'b0, b_w};
    end else if (g_w >= b_w) begin
      side_nxt.hcase = hrc_pkg::HC_GREEN;
      diff_w = {1'b0, b_w} - {1'b0, r_w};
    end else begin
      side_nxt.hcase = hrc_pkg::HC_BLUE;
      diff_w = {1'b0, r_w} - {1'b0, g_w};
    end
    side_nxt.neg = diff_w[CB];
    absd_w = diff_w[CB] ? CB'(-diff_w) : diff_w[CB-1:0];
    side_nxt.gray = (delta_w == '0);
    side_nxt.black = (mx_w == '0);
    side_nxt.vmax = mx_w;
    hue_d1_nxt = hrc_pkg::div_init({absd_w, CB'(0)}, delta_w);
    sat_d1_nxt = hrc_pkg::div_init(({delta_w, CB'(0)}) - PB'(delta_w), mx_w);
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    hue_d0_r  <= hue_d1_nxt;
    sat_d0_r  <= sat_d1_nxt;
    for (int i = 0; i < NS; i++) begin
      side_r[i+1] <= side_r[i];
    end
  end

  assign hue_d[0] = hue_d0_r;
  assign sat_d[0] = sat_d0_r;

  for (genvar k = 0; k < NS; k++) begin : g_div
    hrc_div_stage u_hue_div (
      .clk   (clk),
      .d_in  (hue_d[k]),
      .d_out (hue_d[k+1])
    );
    hrc_div_stage u_sat_div (
      .clk   (clk),
      .d_in  (sat_d[k]),
      .d_out (sat_d[k+1])
    );
  end

  // hue = offset +/- 256*|diff|/delta, floored, then wrapped below 1536
  always_comb begin
    case (side_r[NS].hcase)
      hrc_pkg::HC_RED:   ofs_w = hrc_pkg::HUE_OFS_RED;
      hrc_pkg::HC_GREEN: ofs_w = hrc_pkg::HUE_OFS_GREEN;
      hrc_pkg::HC_BLUE:  ofs_w = hrc_pkg::HUE_OFS_BLUE;
      default:           ofs_w = hrc_pkg::HUE_OFS_RED;
    endcase
    adj_w = (hue_d[NS].rem != '0);
    if (side_r[NS].neg) begin
      h_w = ofs_w - HC'(hue_d[NS].quo) - HC'(adj_w);
    end else begin
      h_w = ofs_w + HC'(hue_d[NS].quo);
    end
    if (h_w >= HC'(hrc_pkg::HUE_FULL)) begin
      hw_w = h_w - HC'(hrc_pkg::HUE_FULL);
    end else begin
      hw_w = h_w;
    end
    res.first_out = side_r[NS].gray ? '0 : hw_w[hrc_pkg::HUE_BITS-1:0];
    res.second_out = side_r[NS].black ? '0 : sat_d[NS].quo[CB-1:0];
    res.third_out = side_r[NS].vmax;
  end

endmodule

### design/hsv_rgb_converter.sv
// hsv_rgb_converter: HSV <-> RGB conversion, one request per clock.
// out_valid strobes once a request has passed the 4 compute stages and the
// output register; throughput one request per clock.
// The divider yields 9 quotient bits, 3 per pipeline stage.
// busy stays low; the result strobe cannot be held off.
// Reset (rst_n, sync) clears the valid bits, dropping requests in flight.
module hsv_rgb_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hrc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output hrc_pkg::out_item_t out_data
);

  localparam int NSTG = hrc_pkg::DIV_STAGES + 1;

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] act_r, act_nxt;
  logic out_valid_r, out_valid_nxt;
  hrc_pkg::out_item_t out_data_r, out_data_nxt;
  hrc_pkg::out_item_t rgb_res, hsv_res;

  assign busy = 1'b0;

  hrc_hsv2rgb u_hsv2rgb (
    .clk     (clk),
    .in_item (in_data),
    .res     (rgb_res)
  );

  hrc_rgb2hsv u_rgb2hsv (
    .clk     (clk),
    .in_item (in_data),
    .res     (hsv_res)
  );

  always_comb begin
    vld_nxt = {vld_r[NSTG-2:0], start & ~busy};
    act_nxt = {act_r[NSTG-2:0], in_data.action};
    out_valid_nxt = vld_r[NSTG-1];
    out_data_nxt = act_r[NSTG-1] ? hsv_res : rgb_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r <= act_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_strobe_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 5))
    else $error("result strobe without a request");

  a_rgb_has_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(!in_data.action, 5)) |->
      (out_data.first_out == hrc_pkg::HUE_BITS'($past(in_data.third_chan, 5)) ||
       out_data.second_out == $past(in_data.third_chan, 5) ||
       out_data.third_out == $past(in_data.third_chan, 5)))
    else $error("no RGB channel equals value");

  a_value_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.action, 5)) |->
      (out_data.third_out >= $past(in_data.second_chan, 5) &&
       out_data.third_out >= $past(in_data.third_chan, 5)))
    else $error("value below a channel");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_data.action, 5)) |->
      (out_data.first_out < hrc_pkg::HUE_FULL))
    else $error("hue out of range");

endmodule

### tb/hsv_rgb_converter_tb.sv
// hsv_rgb_converter_tb: self-checking bench for the HSV <-> RGB converter.
// Depends on hrc_pkg (payload structs, sector enum, hue offsets) and the DUT.
module hsv_rgb_converter_tb;
  import hrc_pkg::*;

  localparam int HUE_STEP = 256;
  localparam int N_RANDOM = 1850;
  localparam int N_CALM   = 300;   // tail of the run with no gaps

  // Keeps the expected colors in request order and checks results against them.
  class color_scoreboard;
    out_item_t pending_colors[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function out_item_t predict_color(in_item_t req);
      out_item_t res;
      int        h, s, v, c, x, m, f;
      int        r, g, b, mx, mn, delta, num, hue, sat;
      sector_t   sec;
      if (req.action == 1'b0) begin
        h = req.first_chan;
        s = req.second_chan;
        v = req.third_chan;
        if (h >= int'(HUE_FULL)) h -= int'(HUE_FULL);
        sec = sector_t'(h / HUE_STEP);
        f = h % HUE_STEP;
        c = v * s / int'(CHAN_MAX);
        if ((h / HUE_STEP) % 2 == 0) x = c * f / HUE_STEP;
        else x = c * (HUE_STEP - f) / HUE_STEP;
        m = v - c;
        case (sec)
          SEC_RY: begin r = c; g = x; b = 0; end
          SEC_YG: begin r = x; g = c; b = 0; end
          SEC_GC: begin r = 0; g = c; b = x; end
          SEC_CB: begin r = 0; g = x; b = c; end
          SEC_BM: begin r = x; g = 0; b = c; end
          default: begin r = c; g = 0; b = x; end
        endcase
        res.first_out  = HUE_BITS'(r + m);
        res.second_out = CHAN_BITS'(g + m);
        res.third_out  = CHAN_BITS'(b + m);
      end else begin
        r = req.first_chan;
        g = req.second_chan;
        b = req.third_chan;
        if (r > int'(CHAN_MAX)) r = int'(CHAN_MAX);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        hue = 0;
        sat = 0;
        if (delta != 0) begin
          // ties resolve red first, then green
          if (mx == r) num = int'(HUE_OFS_RED) * delta + HUE_STEP * (g - b);
          else if (mx == g) num = int'(HUE_OFS_GREEN) * delta + HUE_STEP * (b - r);
          else num = int'(HUE_OFS_BLUE) * delta + HUE_STEP * (r - g);
          hue = num / delta;
          if (hue >= int'(HUE_FULL)) hue -= int'(HUE_FULL);
        end
        if (mx != 0) sat = delta * int'(CHAN_MAX) / mx;
        res.first_out  = HUE_BITS'(hue);
        res.second_out = CHAN_BITS'(sat);
        res.third_out  = CHAN_BITS'(mx);
      end
      return res;
    endfunction

    function void note_request(in_item_t req);
      pending_colors.push_back(predict_color(req));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d/%0d/%0d", $time,
                 got.first_out, got.second_out, got.third_out);
        errors++;
        return;
      end
      exp = pending_colors.pop_front();
      if (got.first_out !== exp.first_out) begin
        $display("%0t: first_out expected %0d got %0d", $time, exp.first_out, got.first_out);
        errors++;
      end
      if (got.second_out !== exp.second_out) begin
        $display("%0t: second_out expected %0d got %0d", $time, exp.second_out,
                 got.second_out);
        errors++;
      end
      if (got.third_out !== exp.third_out) begin
        $display("%0t: third_out expected %0d got %0d", $time, exp.third_out, got.third_out);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_colors.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  color_scoreboard sb = new();

  hsv_rgb_converter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pre-edge values are sampled here; results checked before the new request is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_request(in_data);
    end
  end

  task automatic send_request(input in_item_t req);
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_fields(input logic act, input int first, input int second,
                             input int third);
    in_item_t req;
    req.action      = act;
    req.first_chan  = HUE_BITS'(first);
    req.second_chan = CHAN_BITS'(second);
    req.third_chan  = CHAN_BITS'(third);
    send_request(req);
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off new requests until every result is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    req.action = 1'($urandom_range(1));
    pick = $urandom_range(15);
    if (pick == 0) req.first_chan = HUE_BITS'($urandom_range(2047));
    else if (req.action == 1'b0) req.first_chan = HUE_BITS'($urandom_range(1535));
    else req.first_chan = HUE_BITS'($urandom_range(255));
    req.second_chan = CHAN_BITS'($urandom_range(255));
    req.third_chan  = CHAN_BITS'($urandom_range(255));
    case (pick)
      1: req.second_chan = CHAN_BITS'($urandom_range(1) * 255);
      2: begin
        // gray for an RGB request
        req.second_chan = req.first_chan[CHAN_BITS-1:0];
        req.third_chan  = req.first_chan[CHAN_BITS-1:0];
      end
      3: req.third_chan = CHAN_BITS'($urandom_range(1) * 255);
      4: req.second_chan = req.first_chan[CHAN_BITS-1:0];
      5: req.third_chan = req.second_chan;
      default: ;
    endcase
    return req;
  endfunction

  initial begin
    int  waited;
    bit  calm_block;
    start   <= 1'b0;
    in_data <= '0;
    rst_n   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // HSV: black, every sector edge, hue wrap
    send_fields(1'b0, 0, 0, 0);
    send_fields(1'b0, 0, 255, 255);
    send_fields(1'b0, 255, 255, 255);
    send_fields(1'b0, 256, 255, 255);
    send_fields(1'b0, 511, 255, 255);
    send_fields(1'b0, 512, 255, 255);
    send_fields(1'b0, 767, 255, 200);
    send_fields(1'b0, 768, 255, 255);
    send_fields(1'b0, 1024, 128, 255);
    send_fields(1'b0, 1280, 255, 255);
    send_fields(1'b0, 1535, 255, 255);
    send_fields(1'b0, 1536, 255, 255);
    send_fields(1'b0, 2047, 200, 100);
    // RGB: black, white, gray, ties, hue rounding near wrap, red saturation
    send_fields(1'b1, 0, 0, 0);
    send_fields(1'b1, 255, 255, 255);
    send_fields(1'b1, 128, 128, 128);
    send_fields(1'b1, 255, 0, 0);
    send_fields(1'b1, 255, 255, 0);
    send_fields(1'b1, 0, 255, 255);
    send_fields(1'b1, 255, 0, 255);
    send_fields(1'b1, 0, 0, 255);
    send_fields(1'b1, 255, 0, 1);
    send_fields(1'b1, 255, 1, 0);
    send_fields(1'b1, 2047, 10, 20);
    send_fields(1'b1, 300, 255, 0);
    drain();

    calm_block = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) calm_block = ($urandom_range(3) == 0);
      if (i == 600 || i == 1200) drain();
      if (i < N_RANDOM - N_CALM && !calm_block && $urandom_range(3) == 0)
        idle($urandom_range(1, 10));
      send_request(random_request());
    end
    start <= 1'b0;

    waited = 0;
    while (sb.outstanding() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
